// ===== src/pdr_pkg.sv =====
// Shared types, constants and register codes of the packet deframer.
`default_nettype none
package pdr_pkg;

    // Default sizes
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_PAYLOAD_DEF  = 48;

    // Frame layout and per-byte result bound
    localparam int HEADER_BYTES   = 7;
    localparam int FRAME_OVERHEAD = 8;
    localparam int RESULT_LIMIT   = 56;

    // Configuration register indexes
    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_END     = 2'd2;
    localparam logic [1:0] CFG_MAXLEN  = 2'd3;

    // Configuration reset values
    localparam logic [7:0] START_RST   = 8'd170;
    localparam logic [7:0] VERSION_RST = 8'd1;
    localparam logic [7:0] END_RST     = 8'd85;
    localparam logic [5:0] MAXLEN_RST  = 6'd48;

    // Live configuration seen by the scanner
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] version_byte;
        logic [7:0] end_marker;
        logic [5:0] limit;
    } cfg_t;

    // One result, without the end-of-run flag
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [5:0]  payload_length;
        logic        has_data;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic        frame_end;
    } res_t;

    // Scanner to result stage
    typedef struct packed {
        logic push;
        logic flush;
        res_t res;
    } emit_req_t;

endpackage
`default_nettype wire

// ===== src/pdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/pdr_inq.sv =====
// Two-entry input queue between the receive channel and the scanner.
`default_nettype none
module pdr_inq (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            q_valid,
    output logic [7:0]      q_byte,
    input  wire logic       q_pop
);

    logic [1:0] count_reg, count_next;
    logic [7:0] head_reg, head_next;
    logic [7:0] tail_reg, tail_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_byte   = head_reg;
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Slot update: head is the oldest byte
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        priority if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = in_byte;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = in_byte;
            end
        end
        else if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = in_byte;
            end
            else
            begin
                tail_next = in_byte;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
`default_nettype wire

// ===== src/pdr_emit.sv =====
// Result stage: holds the newest result until the end-of-run flag is known.
`default_nettype none
module pdr_emit
    import pdr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire emit_req_t req,
    output logic           rdy,
    output logic           out_valid,
    input  wire logic      out_ready,
    output res_t           out_res,
    output logic           out_run_end
);

    logic pend_valid_reg, pend_valid_next;
    res_t pend_reg, pend_next;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    logic run_end_reg, run_end_next;
    logic out_free;

    assign out_free    = !out_valid_reg || out_ready;
    assign rdy         = !pend_valid_reg || out_free;
    assign out_valid   = out_valid_reg;
    assign out_res     = out_reg;
    assign out_run_end = run_end_reg;

    // Move the held result forward when a newer one arrives or the run closes
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        run_end_next    = run_end_reg;
        priority if (req.push && rdy)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                run_end_next   = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = req.res;
            pend_valid_next = 1'b1;
        end
        else if (req.flush && rdy)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                run_end_next   = 1'b1;
                out_valid_next = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        run_end_reg <= run_end_next;
    end

`ifndef NO_ASSERTIONS
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req.flush && !req.push && rdy) |=> !pend_valid_reg)
        else $error("held result left after run closed");
    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push && rdy) |=> pend_valid_reg)
        else $error("pushed result not held");
    a_push_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push && rdy && pend_valid_reg) |=> (out_valid_reg && !run_end_reg))
        else $error("earlier result not forwarded as mid-run");
`endif

endmodule
`default_nettype wire

// ===== src/pdr_scan.sv =====
// Back end: byte buffer, resync scan, header and end-marker checks, payload walk.
`default_nettype none
module pdr_scan
    import pdr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       q_valid,
    input  wire logic [7:0] q_byte,
    output logic            q_pop,
    input  wire logic       emit_rdy,
    output emit_req_t       req
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    // Scanner states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TOP    = 3'd1;
    localparam logic [2:0] S_CHK0   = 3'd2;
    localparam logic [2:0] S_HDR    = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_CHKEND = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_FLUSH  = 3'd7;

    // Header byte positions
    localparam logic [2:0] H_VER    = 3'd1;
    localparam logic [2:0] H_TYPE   = 3'd2;
    localparam logic [2:0] H_SEQLO  = 3'd3;
    localparam logic [2:0] H_SEQHI  = 3'd4;
    localparam logic [2:0] H_LENLO  = 3'd5;
    localparam logic [2:0] H_LENHI  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [2:0]    k_reg, k_next;
    logic [5:0]    n_reg, n_next;
    logic [5:0]    idx_reg, idx_next;
    logic [7:0]    ver_reg, ver_next;
    logic [7:0]    type_reg, type_next;
    logic [15:0]   seq_reg, seq_next;
    logic [7:0]    lenlo_reg, lenlo_next;
    logic [7:0]    lenhi_reg, lenhi_next;

    logic          ram_we;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [AW-1:0] wp_inc, rp_inc;
    logic [AW-1:0] held;
    logic [AW:0]   need;
    logic [5:0]    len6, r6;
    logic [6:0]    n_sum;
    logic          len_ok, frame_last, has_data;

    // Circular pointer advance; inc always stays below the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [6:0] inc);
        logic [AW:0] s;
        s = {1'b0, p} + (AW+1)'(inc);
        if (s >= (AW+1)'(BUFFER_DEPTH))
        begin
            s = s - (AW+1)'(BUFFER_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    pdr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (q_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Occupancy and frame arithmetic
    always_comb
    begin
        logic [AW:0] diff;
        diff       = (AW+1)'(BUFFER_DEPTH) + {1'b0, wp_reg} - {1'b0, rp_reg};
        held       = (wp_reg >= rp_reg) ? (wp_reg - rp_reg) : diff[AW-1:0];
        wp_inc     = wrap_add(wp_reg, 7'd1);
        rp_inc     = wrap_add(rp_reg, 7'd1);
        len6       = lenlo_reg[5:0];
        r6         = (len6 == 6'd0) ? 6'd1 : len6;
        len_ok     = (lenhi_reg == 8'd0) && (lenlo_reg <= {2'b00, cfg.limit});
        need       = (AW+1)'(FRAME_OVERHEAD) + (AW+1)'(len6);
        n_sum      = {1'b0, n_reg} + {1'b0, r6};
        frame_last = ((idx_reg + 6'd1) == r6);
        has_data   = (len6 != 6'd0);
    end

    // Result under construction
    always_comb
    begin
        req                    = '0;
        req.res.frame_type     = type_reg;
        req.res.sequence_res   = seq_reg;
        req.res.payload_length = len6;
        req.res.has_data       = has_data;
        req.res.data_byte      = has_data ? rdata : 8'd0;
        req.res.byte_index     = has_data ? idx_reg : 6'd0;
        req.res.frame_end      = frame_last;
        req.push               = (state_reg == S_EMIT);
        req.flush              = (state_reg == S_FLUSH);
    end

    // Scan sequencer
    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        ver_next   = ver_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        lenlo_next = lenlo_reg;
        lenhi_next = lenhi_reg;
        ram_we     = 1'b0;
        raddr      = rp_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // Append the byte unless the buffer is full
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    n_next = 6'd0;
                    if (wp_inc != rp_reg)
                    begin
                        ram_we  = 1'b1;
                        wp_next = wp_inc;
                    end
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                raddr      = rp_reg;
                state_next = (held == '0) ? S_FLUSH : S_CHK0;
            end
            S_CHK0:
            begin
                if (rdata != cfg.start_marker)
                begin
                    rp_next    = rp_inc;
                    state_next = S_TOP;
                end
                else if (held < AW'(FRAME_OVERHEAD))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next     = H_VER;
                    raddr      = rp_inc;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                // One header byte per cycle
                raddr = wrap_add(rp_reg, {4'd0, k_reg} + 7'd1);
                unique case (k_reg)
                    H_VER:   ver_next   = rdata;
                    H_TYPE:  type_next  = rdata;
                    H_SEQLO: seq_next   = {seq_reg[15:8], rdata};
                    H_SEQHI: seq_next   = {rdata, seq_reg[7:0]};
                    H_LENLO: lenlo_next = rdata;
                    default: lenhi_next = rdata;
                endcase
                if (k_reg == H_LENHI)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_EVAL:
            begin
                if ((ver_reg != cfg.version_byte) || !len_ok)
                begin
                    rp_next    = rp_inc;
                    state_next = S_TOP;
                end
                else if ({1'b0, held} < need)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    raddr      = wrap_add(rp_reg, 7'(HEADER_BYTES) + {1'b0, len6});
                    state_next = S_CHKEND;
                end
            end
            S_CHKEND:
            begin
                if (rdata != cfg.end_marker)
                begin
                    rp_next    = rp_inc;
                    state_next = S_TOP;
                end
                else if (n_sum > 7'(RESULT_LIMIT))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next   = 6'd0;
                    raddr      = wrap_add(rp_reg, 7'(HEADER_BYTES));
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Hold the read address while the result stage stalls
                raddr = wrap_add(rp_reg, 7'(HEADER_BYTES) + {1'b0, idx_reg});
                if (emit_rdy)
                begin
                    if (frame_last)
                    begin
                        rp_next    = wrap_add(rp_reg, 7'(FRAME_OVERHEAD) + {1'b0, len6});
                        n_next     = n_sum[5:0];
                        state_next = S_TOP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                        raddr    = wrap_add(rp_reg, 7'(HEADER_BYTES) + {1'b0, idx_reg} + 7'd1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (emit_rdy)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            k_reg     <= 3'd0;
            n_reg     <= 6'd0;
            idx_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ver_reg   <= ver_next;
        type_reg  <= type_next;
        seq_reg   <= seq_next;
        lenlo_reg <= lenlo_next;
        lenhi_reg <= lenhi_next;
    end

`ifndef NO_ASSERTIONS
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("buffer written outside byte intake");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (wp_reg != rp_reg))
        else $error("write pointer caught the read pointer");
    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (n_sum <= 7'(RESULT_LIMIT)))
        else $error("result count of one byte above bound");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg < r6))
        else $error("payload index past frame length");
`endif

endmodule
`default_nettype wire

// ===== src/packet_deframer_resync_unit.sv =====
// Top level of the delimited packet deframer with resync.
// Flow: a byte is written to the buffer in the same cycle that it leaves the input queue;
// each dropped leading byte passes S_TOP and S_CHK0, each header check adds S_HDR for
// the six header bytes and S_EVAL, each end-marker check adds S_CHKEND, then S_EMIT gives
// one result per cycle while the output is taken, and S_FLUSH closes the run. The single
// buffer read port sets the pace: a new byte is taken only after the scan ends; two bytes queue at the input meanwhile.
// Reset: pointers empty, configuration registers at defaults; buffer contents undefined, no clearing.
`default_nettype none
module packet_deframer_resync_unit
    import pdr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_type,
    output logic [15:0]      sequence_res,
    output logic [5:0]       payload_length,
    output logic             has_data,
    output logic [7:0]       data_byte,
    output logic [5:0]       byte_index,
    output logic             frame_end,
    output logic             run_end
);

    logic [7:0] start_reg, version_reg, end_reg;
    logic [5:0] maxlen_reg;
    cfg_t       cfg;
    logic       q_valid, q_pop;
    logic [7:0] q_byte;
    logic       emit_rdy;
    emit_req_t  req;
    res_t       out_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_RST;
            version_reg <= VERSION_RST;
            end_reg     <= END_RST;
            maxlen_reg  <= MAXLEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START:   start_reg   <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data;
                CFG_END:     end_reg     <= cfg_data;
                CFG_MAXLEN:  maxlen_reg  <= cfg_data[5:0];
            endcase
        end
    end

    // Effective length limit is the smaller of the register and the payload size
    always_comb
    begin
        cfg.start_marker = start_reg;
        cfg.version_byte = version_reg;
        cfg.end_marker   = end_reg;
        cfg.limit        = (maxlen_reg > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : maxlen_reg;
    end

    pdr_inq u_inq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_byte   (q_byte),
        .q_pop    (q_pop)
    );

    pdr_scan #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_byte   (q_byte),
        .q_pop    (q_pop),
        .emit_rdy (emit_rdy),
        .req      (req)
    );

    pdr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rdy         (emit_rdy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res),
        .out_run_end (run_end)
    );

    // Result fields
    assign frame_type     = out_res.frame_type;
    assign sequence_res   = out_res.sequence_res;
    assign payload_length = out_res.payload_length;
    assign has_data       = out_res.has_data;
    assign data_byte      = out_res.data_byte;
    assign byte_index     = out_res.byte_index;
    assign frame_end      = out_res.frame_end;

endmodule
`default_nettype wire
